>>> rtl/life_automaton_generation_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the life engine checker
// Each macro expands to one labeled concurrent assertion on a rising clock.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GENERATION_ENGINE_TOP_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_ENGINE_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define LAGE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lage assertion failed");

// Antecedent implies consequent in the following cycle
`define LAGE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lage assertion failed");

`endif

>>> rtl/lage_pkg.sv
// ----------------------------------------------------------------------------
// lage_pkg
// Types and constants shared by the life engine controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lage_pkg;

  // Board geometry
  localparam int BOARD_MAX = 64;
  localparam int ADDR_W    = $clog2(BOARD_MAX);
  localparam int SIZE_W    = 7;
  localparam int CNT_W     = 4;

  // B3/S23 rule counts
  localparam logic [CNT_W-1:0] LIFE_SURVIVE = 4'd2;
  localparam logic [CNT_W-1:0] LIFE_BIRTH   = 4'd3;

  // Operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // One input item
  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] column;
    logic              cell_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic cell_out;
    logic changed;
  } result_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MODIFY,
    ST_GEN,
    ST_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              cap_item;
    logic              rd_en;
    logic              rd_gen;
    logic [ADDR_W-1:0] gen_addr;
    logic              mod_en;
    logic              shift;
    logic              shift_row0;
    logic              cap_row0;
    logic              gen_wr;
    logic [ADDR_W-1:0] gen_row;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] n_use;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/life_automaton_generation_engine_top.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_engine_top
// Toroidal B3/S23 board of up to 64 by 64 cells with cell access and stepping.
// ----------------------------------------------------------------------------
// An item passes the fetch, modify and result states for write and read, fetch
// and result for an unknown op, and fetch, the row sweep through the single-read
// board memory and result for a generation. Items are taken one at a time: a new
// item is accepted only while the block is idle (busy low).
// done is a one-cycle strobe; the receiver cannot stall. Reset clears the board
// at once through per-row valid bits and sets the side to 64.
`default_nettype none

module life_automaton_generation_engine_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lage_pkg::item_t             item,
  output logic                             done,
  output lage_pkg::result_t                result,
  input  wire logic                        cfg_we,
  input  wire logic [lage_pkg::SIZE_W-1:0] cfg_data
);

  import lage_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller
  lage_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath
  lage_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sts      (sts),
    .result   (result)
  );

endmodule

`default_nettype wire

>>> rtl/lage_ram.sv
// ----------------------------------------------------------------------------
// lage_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lage_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lage_datapath.sv
// ----------------------------------------------------------------------------
// lage_datapath
// Board memory, row valid bits, three-row window and the B3/S23 row update.
// ----------------------------------------------------------------------------
`default_nettype none

module lage_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lage_pkg::cmd_t            cmd,
  input  wire lage_pkg::item_t           item,
  input  wire logic                      cfg_we,
  input  wire logic [lage_pkg::SIZE_W-1:0] cfg_data,
  output lage_pkg::sts_t                 sts,
  output lage_pkg::result_t              result
);

  import lage_pkg::*;

  item_t               item_q;
  logic [SIZE_W-1:0]   side_cfg;
  logic [SIZE_W-1:0]   n_use;
  logic [ADDR_W-1:0]   n_m1;
  logic                in_range;
  logic [BOARD_MAX-1:0] valid;
  logic                rd_valid;
  logic [ADDR_W-1:0]   raddr;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [BOARD_MAX-1:0] wdata;
  logic [BOARD_MAX-1:0] rdata;
  logic [BOARD_MAX-1:0] rd_row;
  logic [BOARD_MAX-1:0] w_up;
  logic [BOARD_MAX-1:0] w_cur;
  logic [BOARD_MAX-1:0] w_dn;
  logic [BOARD_MAX-1:0] row0;
  logic [BOARD_MAX-1:0] mask;
  logic [BOARD_MAX-1:0] life_row;
  logic [BOARD_MAX-1:0] new_row;
  logic [BOARD_MAX-1:0] mod_row;
  logic                cell_out;
  logic                changed;
  logic                item_wr;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      item_q <= item;
    end
  end

  // Size register, clamped to 2..BOARD_MAX for use
  always_ff @(posedge clk) begin
    if (rst) begin
      side_cfg <= SIZE_W'(BOARD_MAX);
    end else if (cfg_we) begin
      side_cfg <= cfg_data;
    end
  end

  always_comb begin
    if (side_cfg < SIZE_W'(2)) begin
      n_use = SIZE_W'(2);
    end else if (side_cfg > SIZE_W'(BOARD_MAX)) begin
      n_use = SIZE_W'(BOARD_MAX);
    end else begin
      n_use = side_cfg;
    end
  end

  assign n_m1     = ADDR_W'(n_use - SIZE_W'(1));
  assign in_range = ({1'b0, item_q.row} < n_use) && ({1'b0, item_q.column} < n_use);

  assign sts.op    = item_q.operation;
  assign sts.n_use = n_use;

  // Columns in use
  always_comb begin
    for (int i = 0; i < BOARD_MAX; i++) begin
      mask[i] = SIZE_W'(i) < n_use;
    end
  end

  // Memory ports
  assign raddr   = cmd.rd_gen ? cmd.gen_addr : item_q.row;
  assign item_wr = cmd.mod_en && (item_q.operation == OP_WRITE) && in_range;
  assign we      = cmd.gen_wr || item_wr;
  assign waddr   = cmd.gen_wr ? cmd.gen_row : item_q.row;
  assign wdata   = cmd.gen_wr ? new_row : mod_row;

  lage_ram #(
    .WIDTH (BOARD_MAX),
    .DEPTH (BOARD_MAX)
  ) u_board (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Row valid bits: a row never written reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid <= valid[raddr];
    end
  end

  assign rd_row = rdata & {BOARD_MAX{rd_valid}};

  // Single cell update for a write
  always_comb begin
    mod_row = rd_row;
    mod_row[item_q.column] = item_q.cell_in;
  end

  // Three-row window; last row wraps to the saved old row zero
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      w_up  <= w_cur;
      w_cur <= w_dn;
      w_dn  <= cmd.shift_row0 ? row0 : rd_row;
    end
    if (cmd.cap_row0) begin
      row0 <= rd_row;
    end
  end

  // Neighbor count and rule for every column of the center row
  always_comb begin
    logic [CNT_W-1:0] cnt;
    int               lf;
    int               rt;
    logic             u_l, u_r, c_l, c_r, d_l, d_r;
    life_row = '0;
    for (int c = 0; c < BOARD_MAX; c++) begin
      lf = (c == 0) ? 0 : c - 1;
      rt = (c == BOARD_MAX - 1) ? 0 : c + 1;
      if (c == 0) begin
        u_l = w_up[n_m1];
        c_l = w_cur[n_m1];
        d_l = w_dn[n_m1];
      end else begin
        u_l = w_up[lf];
        c_l = w_cur[lf];
        d_l = w_dn[lf];
      end
      if (SIZE_W'(c) == n_use - SIZE_W'(1)) begin
        u_r = w_up[0];
        c_r = w_cur[0];
        d_r = w_dn[0];
      end else begin
        u_r = w_up[rt];
        c_r = w_cur[rt];
        d_r = w_dn[rt];
      end
      cnt = CNT_W'(u_l) + CNT_W'(w_up[c]) + CNT_W'(u_r)
          + CNT_W'(c_l) + CNT_W'(c_r)
          + CNT_W'(d_l) + CNT_W'(w_dn[c]) + CNT_W'(d_r);
      life_row[c] = (cnt == LIFE_BIRTH) || (w_cur[c] && (cnt == LIFE_SURVIVE));
    end
  end

  // Cells beyond the board in use keep their value
  assign new_row = (w_cur & ~mask) | (life_row & mask);

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      cell_out <= 1'b0;
      changed  <= 1'b0;
    end else begin
      if (cmd.gen_wr && (|((life_row ^ w_cur) & mask))) begin
        changed <= 1'b1;
      end
      if (cmd.mod_en && (item_q.operation == OP_READ)) begin
        cell_out <= in_range && rd_row[item_q.column];
      end
    end
  end

  assign result.cell_out = cell_out;
  assign result.changed  = changed;

endmodule

`default_nettype wire

>>> rtl/lage_ctrl.sv
// ----------------------------------------------------------------------------
// lage_ctrl
// Sequencer for single-cell access and for the row sweep of a generation.
// ----------------------------------------------------------------------------
`default_nettype none

module lage_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire lage_pkg::sts_t sts,
  output lage_pkg::cmd_t      cmd,
  output logic                busy,
  output logic                done
);

  import lage_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [SIZE_W-1:0] cnt;
  logic [SIZE_W-1:0] cnt_next;
  logic [SIZE_W-1:0] n;

  assign n = sts.n_use;

  // State and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.cap_item = 1'b1;
          state_next   = ST_FETCH;
        end
      end
      ST_FETCH: begin
        unique case (sts.op) inside
          OP_STEP: begin
            cnt_next   = '0;
            state_next = ST_GEN;
          end
          OP_WRITE, OP_READ: begin
            cmd.rd_en  = 1'b1;
            state_next = ST_MODIFY;
          end
          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end
      ST_MODIFY: begin
        cmd.mod_en = 1'b1;
        state_next = ST_RESULT;
      end
      ST_GEN: begin
        // reads: row n-1, then rows 0..n-1
        cmd.rd_gen   = 1'b1;
        cmd.rd_en    = (cnt <= n);
        cmd.gen_addr = (cnt == '0) ? ADDR_W'(n - SIZE_W'(1)) : ADDR_W'(cnt - SIZE_W'(1));
        // window shifts in each row as its read data shows
        cmd.cap_row0   = (cnt == SIZE_W'(2));
        cmd.shift      = (cnt >= SIZE_W'(1)) && (cnt <= n + SIZE_W'(2));
        cmd.shift_row0 = (cnt == n + SIZE_W'(2));
        // row k is written at count k+4
        cmd.gen_wr  = (cnt >= SIZE_W'(4));
        cmd.gen_row = ADDR_W'(cnt - SIZE_W'(4));
        if (cnt == n + SIZE_W'(3)) begin
          state_next = ST_RESULT;
        end else begin
          cnt_next = cnt + SIZE_W'(1);
        end
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_RESULT);

endmodule

`default_nettype wire

>>> rtl/lage_checker.sv
// ----------------------------------------------------------------------------
// lage_checker
// Port-level timing checks for the life engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_automaton_generation_engine_top_macros.svh"

module lage_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // Result strobe lasts one cycle
  `LAGE_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // Result only shows while an item is held
  `LAGE_ASSERT_SAME(a_done_busy, clk, rst, done, busy)
  // An accepted item makes the block busy and never completes at once
  `LAGE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)

endmodule

bind life_automaton_generation_engine_top lage_checker u_lage_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the toroidal life generation engine
// Drives cell writes, cell reads, generation steps and unknown ops through the
// start/busy port. A shadow board in the bench predicts every result that the
// directed table does not give. Board sizes are swept between phases, including
// out-of-range values and resizes over stored cells.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import lage_pkg::*;

  // One row of the directed table; want is used only where known is set
  typedef struct {
    item_t   it;
    bit      known;
    result_t want;
  } dir_row_t;

  localparam int PHASE_ITEMS = 114;
  localparam int END_SETTLE  = 80;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  item_t             item = '0;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic              busy;
  logic              done;
  result_t           result;

  // Shadow state of the engine
  logic [63:0]       shadow_board [64];
  logic [SIZE_W-1:0] shadow_side;
  result_t           pending_results [$];
  int                mismatch_count = 0;
  int                results_seen = 0;
  bit                calm = 1'b0;

  // Directed table, run on the reset size of 64
  dir_row_t directed_plan [21] = '{
    '{'{OP_READ,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 1'b0}},  // empty after reset
    '{'{OP_STEP,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 1'b0}},  // empty board stays
    '{'{OP_WRITE, 6'd63, 6'd63, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_READ,  6'd63, 6'd63, 1'b1}, 1'b1, '{1'b1, 1'b0}},
    '{'{OP_WRITE, 6'd0,  6'd0,  1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_WRITE, 6'd0,  6'd63, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_WRITE, 6'd63, 6'd0,  1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_STEP,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b0, 1'b0}},  // block across corners
    '{'{OP_READ,  6'd0,  6'd0,  1'b0}, 1'b1, '{1'b1, 1'b0}},
    '{'{OP_NONE,  6'd63, 6'd63, 1'b1}, 1'b1, '{1'b0, 1'b0}},  // unknown op
    '{'{OP_WRITE, 6'd10, 6'd20, 1'b1}, 1'b0, '{1'b0, 1'b0}},  // blinker
    '{'{OP_WRITE, 6'd10, 6'd21, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_WRITE, 6'd10, 6'd22, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_STEP,  6'd0,  6'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_READ,  6'd9,  6'd21, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_READ,  6'd10, 6'd20, 1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_STEP,  6'd63, 6'd63, 1'b1}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_WRITE, 6'd0,  6'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},  // break the block
    '{'{OP_STEP,  6'd0,  6'd0,  1'b0}, 1'b0, '{1'b0, 1'b0}},
    '{'{OP_READ,  6'd42, 6'd21, 1'b1}, 1'b1, '{1'b0, 1'b0}},
    '{'{OP_WRITE, 6'd42, 6'd21, 1'b0}, 1'b0, '{1'b0, 1'b0}}
  };

  // Board sides per random phase; the last one is drawn at run time
  logic [SIZE_W-1:0] side_plan [13] = '{
    7'd2, 7'd0, 7'd1, 7'd3, 7'd127, 7'd65, 7'd5, 7'd64, 7'd8, 7'd63, 7'd17, 7'd4, 7'd0
  };

  life_automaton_generation_engine_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Side actually used: clamped to 2..64
  function automatic int side_used();
    int n;
    n = shadow_side;
    if (n < 2) n = 2;
    if (n > BOARD_MAX) n = BOARD_MAX;
    return n;
  endfunction

  // One B3/S23 generation on the torus; returns 1 if any cell in use flipped
  function automatic logic evolve_board();
    logic [63:0] nxt [64];
    logic        chg;
    logic        alive;
    logic        born;
    int          n, up, dn, lf, rt, cnt;
    n   = side_used();
    chg = 1'b0;
    for (int r = 0; r < 64; r++) nxt[r] = shadow_board[r];
    for (int r = 0; r < n; r++) begin
      up = (r + n - 1) % n;
      dn = (r + 1) % n;
      for (int c = 0; c < n; c++) begin
        lf  = (c + n - 1) % n;
        rt  = (c + 1) % n;
        cnt = shadow_board[up][lf] + shadow_board[up][c] + shadow_board[up][rt]
            + shadow_board[r][lf] + shadow_board[r][rt]
            + shadow_board[dn][lf] + shadow_board[dn][c] + shadow_board[dn][rt];
        alive = shadow_board[r][c];
        born  = alive ? (cnt == LIFE_SURVIVE || cnt == LIFE_BIRTH) : (cnt == LIFE_BIRTH);
        if (born != alive) chg = 1'b1;
        nxt[r][c] = born;
      end
    end
    for (int r = 0; r < n; r++) shadow_board[r] = nxt[r];
    return chg;
  endfunction

  // Applies one item to the shadow board and returns its result
  function automatic result_t life_item_result(item_t it);
    result_t res;
    int      n;
    res = '0;
    n   = side_used();
    case (it.operation)
      OP_WRITE: begin
        if (it.row < n && it.column < n) shadow_board[it.row][it.column] = it.cell_in;
      end
      OP_STEP: begin
        res.changed = evolve_board();
      end
      OP_READ: begin
        if (it.row < n && it.column < n) res.cell_out = shadow_board[it.row][it.column];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Random item: mostly clustered near an origin so patterns live and wrap
  function automatic item_t random_life_item(int n, int org_r, int org_c);
    item_t it;
    int    pick, sel;
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.operation = OP_WRITE;
    else if (pick < 78) it.operation = OP_READ;
    else if (pick < 95) it.operation = OP_STEP;
    else                it.operation = OP_NONE;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      it.row    = 6'((org_r + $urandom_range(0, 5)) % n);
      it.column = 6'((org_c + $urandom_range(0, 5)) % n);
    end else if (sel < 85) begin
      it.row    = 6'($urandom_range(0, n - 1));
      it.column = 6'($urandom_range(0, n - 1));
    end else begin
      it.row    = 6'($urandom_range(0, 63));
      it.column = 6'($urandom_range(0, 63));
    end
    it.cell_in = ($urandom_range(0, 99) < 60);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on result %0d: %s got %0b expected %0b",
               results_seen, what, got, want);
  endtask

  // Sends one item, with an occasional idle gap first
  task automatic send_item(input item_t it, input bit known, input result_t want);
    result_t res;
    if (!calm && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 75) : $urandom_range(1, 4))
        @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = life_item_result(it);
    pending_results.push_back(known ? want : res);
  endtask

  // Holds the sender off until every pending result is back
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_board_side(input logic [SIZE_W-1:0] side);
    wait_all_results();
    while (busy) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= side;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_side = side;
  endtask

  // Result checker
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", 1'b0, 1'b0);
      end else begin
        exp_res = pending_results.pop_front();
        if (result.cell_out !== exp_res.cell_out)
          report_mismatch("cell_out", result.cell_out, exp_res.cell_out);
        if (result.changed !== exp_res.changed)
          report_mismatch("changed", result.changed, exp_res.changed);
      end
      results_seen++;
    end
  end

  // Stimulus
  initial begin : stimulus
    int n, org_r, org_c;
    for (int r = 0; r < 64; r++) shadow_board[r] = '0;
    shadow_side   = 7'd64;
    side_plan[12] = 7'($urandom_range(0, 127));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i])
      send_item(directed_plan[i].it, directed_plan[i].known, directed_plan[i].want);

    foreach (side_plan[p]) begin
      set_board_side(side_plan[p]);
      calm  = (p == 6);
      n     = side_used();
      org_r = $urandom_range(0, n - 1);
      org_c = $urandom_range(0, n - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 39) begin
          org_r = $urandom_range(0, n - 1);
          org_c = $urandom_range(0, n - 1);
        end
        if ($urandom_range(0, 149) == 0) wait_all_results();
        send_item(random_life_item(n, org_r, org_c), 1'b0, '0);
      end
    end

    wait_all_results();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[life_automaton_generation_engine_top] OK");
    end else begin
      $display("[life_automaton_generation_engine_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("[life_automaton_generation_engine_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/lage_pkg.sv
rtl/lage_ram.sv
rtl/lage_datapath.sv
rtl/lage_ctrl.sv
rtl/life_automaton_generation_engine_top.sv
rtl/lage_checker.sv
tb/tb.sv
